// ----- src/sgr_pkg.sv -----
`timescale 1ns / 1ps

package sgr_pkg;

  localparam int unsigned ParamW   = 16;
  localparam int unsigned RemW     = 5;
  localparam int unsigned RgbW     = 24;
  localparam int unsigned AttrW    = 7;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 80;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] CfgDefaultFg = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgDefaultBg = 1'd1;

  localparam logic [RgbW-1:0] DefaultFgReset = 24'hDCDCDC;
  localparam logic [RgbW-1:0] DefaultBgReset = 24'h000000;

  // Parser phases.
  localparam logic [2:0] PhNormal = 3'd0;
  localparam logic [2:0] PhMode   = 3'd1;
  localparam logic [2:0] PhIndex  = 3'd2;
  localparam logic [2:0] PhRed    = 3'd3;
  localparam logic [2:0] PhGreen  = 3'd4;
  localparam logic [2:0] PhBlue   = 3'd5;

  // Attribute bit positions.
  localparam int unsigned AttrBold      = 0;
  localparam int unsigned AttrItalic    = 1;
  localparam int unsigned AttrUnderline = 2;
  localparam int unsigned AttrBlink     = 3;
  localparam int unsigned AttrReverse   = 4;
  localparam int unsigned AttrHidden    = 5;
  localparam int unsigned AttrStrike    = 6;

  // A colour keeps the unused half at zero, so it can be shown as is.
  typedef struct packed {
    logic            is_rgb;
    logic [7:0]      index;
    logic [RgbW-1:0] rgb;
  } colour_t;

  typedef struct packed {
    colour_t          fg;
    colour_t          bg;
    logic [AttrW-1:0] attr;
    logic [2:0]       phase;
    logic             target_bg;
    logic [15:0]      red_green;
  } sgr_state_t;

  typedef struct packed {
    logic [ParamW-1:0] param;
    logic [RemW-1:0]   remaining_after;
  } sgr_item_t;

  typedef struct packed {
    logic [RgbW-1:0] fg;
    logic [RgbW-1:0] bg;
  } sgr_defaults_t;

  function automatic colour_t make_rgb(input logic [RgbW-1:0] rgb);
    colour_t c;
    c.is_rgb = 1'b1;
    c.index  = 8'd0;
    c.rgb    = rgb;
    return c;
  endfunction

  function automatic colour_t make_index(input logic [7:0] idx);
    colour_t c;
    c.is_rgb = 1'b0;
    c.index  = idx;
    c.rgb    = '0;
    return c;
  endfunction

endpackage

// ----- src/sgr_decode.sv -----
`timescale 1ns / 1ps

module sgr_decode (
  input  sgr_pkg::sgr_state_t    state_i,
  input  sgr_pkg::sgr_item_t     item_i,
  input  sgr_pkg::sgr_defaults_t defaults_i,
  output sgr_pkg::sgr_state_t    state_o
);
  import sgr_pkg::*;

  logic [ParamW-1:0] p;
  logic [RemW-1:0]   rem;
  logic [7:0]        p_lo;
  colour_t           new_colour;
  logic              set_colour;

  assign p    = item_i.param;
  assign rem  = item_i.remaining_after;
  assign p_lo = p[7:0];

  always_comb begin
    state_o    = state_i;
    new_colour = make_index(p_lo);
    set_colour = 1'b0;

    case (state_i.phase)
      PhMode: begin
        if (p == 16'd5 && rem >= 5'd1) begin
          state_o.phase = PhIndex;
        end else if (p == 16'd2 && rem >= 5'd3) begin
          state_o.phase = PhRed;
        end else begin
          state_o.phase = PhNormal;
        end
      end
      PhIndex: begin
        new_colour    = make_index(p_lo);
        set_colour    = 1'b1;
        state_o.phase = PhNormal;
      end
      PhRed: begin
        state_o.red_green = {p_lo, 8'd0};
        state_o.phase     = PhGreen;
      end
      PhGreen: begin
        state_o.red_green = {state_i.red_green[15:8], p_lo};
        state_o.phase     = PhBlue;
      end
      PhBlue: begin
        new_colour    = make_rgb({state_i.red_green, p_lo});
        set_colour    = 1'b1;
        state_o.phase = PhNormal;
      end
      default: begin
        state_o.phase = PhNormal;
        case (p)
          16'd0: begin
            state_o.fg   = make_rgb(defaults_i.fg);
            state_o.bg   = make_rgb(defaults_i.bg);
            state_o.attr = '0;
          end
          16'd1:  state_o.attr[AttrBold]      = 1'b1;
          16'd3:  state_o.attr[AttrItalic]    = 1'b1;
          16'd4:  state_o.attr[AttrUnderline] = 1'b1;
          16'd5:  state_o.attr[AttrBlink]     = 1'b1;
          16'd7:  state_o.attr[AttrReverse]   = 1'b1;
          16'd8:  state_o.attr[AttrHidden]    = 1'b1;
          16'd9:  state_o.attr[AttrStrike]    = 1'b1;
          16'd22: state_o.attr[AttrBold]      = 1'b0;
          16'd23: state_o.attr[AttrItalic]    = 1'b0;
          16'd24: state_o.attr[AttrUnderline] = 1'b0;
          16'd25: state_o.attr[AttrBlink]     = 1'b0;
          16'd27: state_o.attr[AttrReverse]   = 1'b0;
          16'd28: state_o.attr[AttrHidden]    = 1'b0;
          16'd29: state_o.attr[AttrStrike]    = 1'b0;
          16'd39: state_o.fg = make_rgb(defaults_i.fg);
          16'd49: state_o.bg = make_rgb(defaults_i.bg);
          16'd38, 16'd48: begin
            // An extended colour with nothing after it is dropped.
            if (rem != '0) begin
              state_o.target_bg = (p == 16'd48);
              state_o.phase     = PhMode;
            end
          end
          default: begin
            if (p >= 16'd30 && p <= 16'd37) begin
              state_o.fg = make_index(p_lo - 8'd30);
            end else if (p >= 16'd40 && p <= 16'd47) begin
              state_o.bg = make_index(p_lo - 8'd40);
            end else if (p >= 16'd90 && p <= 16'd97) begin
              state_o.fg = make_index(p_lo - 8'd82);
            end else if (p >= 16'd100 && p <= 16'd107) begin
              state_o.bg = make_index(p_lo - 8'd92);
            end
          end
        endcase
      end
    endcase

    if (set_colour) begin
      if (state_i.target_bg) begin
        state_o.bg = new_colour;
      end else begin
        state_o.fg = new_colour;
      end
    end
  end

endmodule

// ----- src/sgr_attribute_decoder_top.sv -----
`timescale 1ns / 1ps

// SGR attribute decoder. Each input item carries one SGR parameter and the
// count of parameters that follow it; each item yields exactly one result
// item holding the updated foreground, background and attribute flags. The
// block takes one item per clock cycle while the output is not stalled: an
// item is registered on entry, decoded by a single combinational step
// against the held colour state, and the result is registered at the
// output, where it is offered. Input and output stall independently only as
// far as the one-entry input and output registers allow. Default colours are
// written through the cfg port and take effect at the next code 0, 39 or 49.
module sgr_attribute_decoder_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                cfg_we_i,
  input  logic [sgr_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [sgr_pkg::RgbW-1:0]            cfg_wdata_i,

  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // param [15:0], remaining_after [20:16], zero [23:21]
  input  logic [sgr_pkg::InDataW-1:0]         s_axis_tdata,

  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // fg_is_rgb [0], fg_index [8:1], fg_red [16:9], fg_green [24:17],
  // fg_blue [32:25], bg_is_rgb [33], bg_index [41:34], bg_red [49:42],
  // bg_green [57:50], bg_blue [65:58], attr_flags [72:66], zero [79:73]
  output logic [sgr_pkg::OutDataW-1:0]        m_axis_tdata
);
  import sgr_pkg::*;

  sgr_defaults_t dflt_q;
  sgr_state_t    state_q, state_d;
  sgr_item_t     item_q;
  logic          in_valid_q;
  logic          out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic          out_free;
  logic          advance;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q.fg <= DefaultFgReset;
      dflt_q.bg <= DefaultBgReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDefaultFg: dflt_q.fg <= cfg_wdata_i;
        CfgDefaultBg: dflt_q.bg <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.param           <= s_axis_tdata[ParamW-1:0];
      item_q.remaining_after <= s_axis_tdata[ParamW+RemW-1:ParamW];
    end
  end

  sgr_decode u_decode (
    .state_i    (state_q),
    .item_i     (item_q),
    .defaults_i (dflt_q),
    .state_o    (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.fg        <= make_rgb(DefaultFgReset);
      state_q.bg        <= make_rgb(DefaultBgReset);
      state_q.attr      <= '0;
      state_q.phase     <= PhNormal;
      state_q.target_bg <= 1'b0;
      state_q.red_green <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {7'd0,
                     state_d.attr,
                     state_d.bg.rgb[7:0], state_d.bg.rgb[15:8], state_d.bg.rgb[23:16],
                     state_d.bg.index, state_d.bg.is_rgb,
                     state_d.fg.rgb[7:0], state_d.fg.rgb[15:8], state_d.fg.rgb[23:16],
                     state_d.fg.index, state_d.fg.is_rgb};
    end
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import sgr_pkg::*;

  // SGR codes.
  localparam int unsigned CodeReset       = 0;
  localparam int unsigned CodeBold        = 1;
  localparam int unsigned CodeItalic      = 3;
  localparam int unsigned CodeUnderline   = 4;
  localparam int unsigned CodeBlink       = 5;
  localparam int unsigned CodeReverse     = 7;
  localparam int unsigned CodeHidden      = 8;
  localparam int unsigned CodeStrike      = 9;
  localparam int unsigned CodeNoBold      = 22;
  localparam int unsigned CodeNoItalic    = 23;
  localparam int unsigned CodeNoUnderline = 24;
  localparam int unsigned CodeNoBlink     = 25;
  localparam int unsigned CodeNoReverse   = 27;
  localparam int unsigned CodeNoHidden    = 28;
  localparam int unsigned CodeNoStrike    = 29;
  localparam int unsigned CodeFgBase      = 30;
  localparam int unsigned CodeFgExtended  = 38;
  localparam int unsigned CodeFgDefault   = 39;
  localparam int unsigned CodeBgBase      = 40;
  localparam int unsigned CodeBgExtended  = 48;
  localparam int unsigned CodeBgDefault   = 49;
  localparam int unsigned CodeFgBright    = 90;
  localparam int unsigned CodeBgBright    = 100;
  localparam int unsigned ColourSpan      = 8;
  localparam int unsigned BrightOffset    = 8;
  // Extended colour modes.
  localparam int unsigned ModeDirect      = 2;
  localparam int unsigned ModeIndexed     = 5;

  localparam int unsigned AttrOnCodes [7] = '{CodeBold, CodeItalic, CodeUnderline, CodeBlink,
                                              CodeReverse, CodeHidden, CodeStrike};
  localparam int unsigned AttrOffCodes [7] = '{CodeNoBold, CodeNoItalic, CodeNoUnderline,
                                               CodeNoBlink, CodeNoReverse, CodeNoHidden,
                                               CodeNoStrike};
  localparam int unsigned ColourBases [4] = '{CodeFgBase, CodeBgBase, CodeFgBright,
                                              CodeBgBright};

  localparam int NumFields = 12;
  localparam int FieldLsb [NumFields] = '{0, 1, 9, 17, 25, 33, 34, 42, 50, 58, 66, 73};
  localparam int FieldWidth [NumFields] = '{1, 8, 8, 8, 8, 1, 8, 8, 8, 8, 7, 7};
  localparam int StallLimit = 3000;
  localparam int MaxPrinted = 40;

  typedef struct {
    logic [ParamW-1:0] param;
    logic [RemW-1:0]   remaining;
    logic              wait_for_idle;
  } sgr_input_t;

  string field_name [NumFields] = '{"fg_is_rgb", "fg_index", "fg_red", "fg_green", "fg_blue",
                                    "bg_is_rgb", "bg_index", "bg_red", "bg_green", "bg_blue",
                                    "attr_flags", "padding"};

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [RgbW-1:0]     cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  sgr_attribute_decoder_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Predicted decoder state.
  colour_t         fg_now;
  colour_t         bg_now;
  logic [AttrW-1:0] attr_now;
  logic [2:0]      phase_now;
  logic            target_bg_now;
  logic [15:0]     red_green_now;
  logic [RgbW-1:0] dflt_fg;
  logic [RgbW-1:0] dflt_bg;

  sgr_input_t          pending_q [$];
  logic [OutDataW-1:0] expected_q [$];
  int unsigned         send_idle_pct;
  int unsigned         recv_idle_pct;
  int unsigned         mismatch_count;
  int unsigned         stall_cycles;
  logic                in_taken;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MaxPrinted) $display("%t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic logic [32:0] colour_bits(input colour_t c);
    return c.is_rgb ? {c.rgb[7:0], c.rgb[15:8], c.rgb[23:16], 8'd0, 1'b1}
                    : {24'd0, c.index, 1'b0};
  endfunction

  // Advances the predicted state by one parameter and returns the packed result.
  function automatic logic [OutDataW-1:0] decode_param(input logic [ParamW-1:0] p,
                                                       input logic [RemW-1:0] rem);
    logic [2:0] next_phase;
    colour_t    picked;
    next_phase = PhNormal;
    picked     = '0;
    case (phase_now)
      PhMode: begin
        if (p == ModeIndexed && rem >= 1) next_phase = PhIndex;
        else if (p == ModeDirect && rem >= 3) next_phase = PhRed;
      end
      PhIndex: begin
        picked = {1'b0, p[7:0], 24'd0};
        if (target_bg_now) bg_now = picked;
        else fg_now = picked;
      end
      PhRed: begin
        red_green_now = {p[7:0], 8'd0};
        next_phase    = PhGreen;
      end
      PhGreen: begin
        red_green_now[7:0] = p[7:0];
        next_phase         = PhBlue;
      end
      PhBlue: begin
        picked = {1'b1, 8'd0, red_green_now, p[7:0]};
        if (target_bg_now) bg_now = picked;
        else fg_now = picked;
      end
      default: begin
        case (p)
          CodeReset: begin
            fg_now   = {1'b1, 8'd0, dflt_fg};
            bg_now   = {1'b1, 8'd0, dflt_bg};
            attr_now = '0;
          end
          CodeBold:        attr_now[AttrBold]      = 1'b1;
          CodeItalic:      attr_now[AttrItalic]    = 1'b1;
          CodeUnderline:   attr_now[AttrUnderline] = 1'b1;
          CodeBlink:       attr_now[AttrBlink]     = 1'b1;
          CodeReverse:     attr_now[AttrReverse]   = 1'b1;
          CodeHidden:      attr_now[AttrHidden]    = 1'b1;
          CodeStrike:      attr_now[AttrStrike]    = 1'b1;
          CodeNoBold:      attr_now[AttrBold]      = 1'b0;
          CodeNoItalic:    attr_now[AttrItalic]    = 1'b0;
          CodeNoUnderline: attr_now[AttrUnderline] = 1'b0;
          CodeNoBlink:     attr_now[AttrBlink]     = 1'b0;
          CodeNoReverse:   attr_now[AttrReverse]   = 1'b0;
          CodeNoHidden:    attr_now[AttrHidden]    = 1'b0;
          CodeNoStrike:    attr_now[AttrStrike]    = 1'b0;
          CodeFgDefault:   fg_now = {1'b1, 8'd0, dflt_fg};
          CodeBgDefault:   bg_now = {1'b1, 8'd0, dflt_bg};
          CodeFgExtended, CodeBgExtended: begin
            // Without a following mode the code does nothing.
            if (rem != 0) begin
              target_bg_now = (p == CodeBgExtended);
              next_phase    = PhMode;
            end
          end
          default: begin
            if (p >= CodeFgBase && p < CodeFgBase + ColourSpan)
              fg_now = {1'b0, 8'(p - CodeFgBase), 24'd0};
            else if (p >= CodeBgBase && p < CodeBgBase + ColourSpan)
              bg_now = {1'b0, 8'(p - CodeBgBase), 24'd0};
            else if (p >= CodeFgBright && p < CodeFgBright + ColourSpan)
              fg_now = {1'b0, 8'(p - CodeFgBright + BrightOffset), 24'd0};
            else if (p >= CodeBgBright && p < CodeBgBright + ColourSpan)
              bg_now = {1'b0, 8'(p - CodeBgBright + BrightOffset), 24'd0};
          end
        endcase
      end
    endcase
    phase_now = next_phase;
    return {7'd0, attr_now, colour_bits(bg_now), colour_bits(fg_now)};
  endfunction

  task automatic check_result(input logic [OutDataW-1:0] got, input logic [OutDataW-1:0] want);
    logic [OutDataW-1:0] g;
    logic [OutDataW-1:0] w;
    for (int f = 0; f < NumFields; f++) begin
      g = (got >> FieldLsb[f]) & ((80'd1 << FieldWidth[f]) - 80'd1);
      w = (want >> FieldLsb[f]) & ((80'd1 << FieldWidth[f]) - 80'd1);
      if (g !== w) report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", field_name[f], g, w));
    end
  endtask

  // Monitor: checks results, predicts accepted items, and watches for a hang.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_taken = 1'b0;
    end else begin
      in_taken = s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) report_mismatch("result item with nothing expected");
        else check_result(m_axis_tdata, expected_q.pop_front());
      end
      if (in_taken)
        expected_q.push_back(decode_param(s_axis_tdata[ParamW-1:0],
                                          s_axis_tdata[ParamW+RemW-1:ParamW]));
      if (in_taken || (m_axis_tvalid && m_axis_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("%t no handshake for %0d cycles", $realtime, StallLimit);
        $display("[sgr_attribute_decoder_top] ERROR");
        $finish;
      end
    end
  end

  // Driver: an item marked wait_for_idle is held back until every result is out.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (pending_q.size() != 0 && !(pending_q[0].wait_for_idle && expected_q.size() != 0)
          && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(InDataW-RemW-ParamW){1'b0}}, pending_q[0].remaining,
                          pending_q[0].param};
        pending_q.delete(0);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic add_item(input int unsigned p, input int unsigned rem, input logic hold = 1'b0);
    sgr_input_t it;
    it.param         = p[ParamW-1:0];
    it.remaining     = rem[RemW-1:0];
    it.wait_for_idle = hold;
    pending_q.push_back(it);
  endtask

  function automatic int unsigned random_channel();
    return ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(255);
  endfunction

  // Queues one SGR sequence: mostly well formed, sometimes cut short or with odd counts.
  task automatic add_sequence(output int unsigned n_items);
    int unsigned codes [$];
    int unsigned parts;
    int unsigned ext;
    int unsigned len;
    int unsigned rem;
    logic        hold;
    parts = ($urandom_range(15) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
    repeat (parts) begin
      ext = $urandom_range(1) ? CodeFgExtended : CodeBgExtended;
      case ($urandom_range(11))
        0: codes.push_back(CodeReset);
        1: codes.push_back(AttrOnCodes[$urandom_range(6)]);
        2: codes.push_back(AttrOffCodes[$urandom_range(6)]);
        3: codes.push_back(ColourBases[$urandom_range(3)] + $urandom_range(ColourSpan - 1));
        4: codes.push_back($urandom_range(1) ? CodeFgDefault : CodeBgDefault);
        5, 6: begin
          codes.push_back(ext);
          codes.push_back(ModeIndexed);
          codes.push_back(random_channel());
        end
        7, 8, 9: begin
          codes.push_back(ext);
          codes.push_back(ModeDirect);
          repeat (3) codes.push_back(random_channel());
        end
        10: begin
          // Unusual mode values.
          codes.push_back(ext);
          codes.push_back($urandom_range(1) ? $urandom_range(65535) : $urandom_range(8));
        end
        default: codes.push_back($urandom_range(1) ? $urandom_range(65535)
                                                    : $urandom_range(10, 21));
      endcase
    end
    // An empty parameter list arrives as a single reset code.
    if (codes.size() == 0) codes.push_back(CodeReset);
    if (codes.size() > 1 && $urandom_range(7) == 0)
      repeat ($urandom_range(1, codes.size() - 1)) void'(codes.pop_back());
    len  = codes.size();
    hold = ($urandom_range(39) == 0);
    foreach (codes[i]) begin
      rem = len - 1 - i;
      if (rem > 31) rem = 31;
      if ($urandom_range(19) == 0) rem = $urandom_range(31);
      add_item(codes[i], rem, hold && i == 0);
    end
    n_items = len;
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned added;
    int unsigned n;
    added = 0;
    while (added < target) begin
      add_sequence(n);
      added += n;
    end
  endtask

  task automatic wait_until_idle();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_default(input logic [CfgIdxW-1:0] idx, input logic [RgbW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgDefaultFg) dflt_fg = value;
    else dflt_bg = value;
  endtask

  initial begin
    fg_now         = {1'b1, 8'd0, DefaultFgReset};
    bg_now         = {1'b1, 8'd0, DefaultBgReset};
    attr_now       = '0;
    phase_now      = PhNormal;
    target_bg_now  = 1'b0;
    red_green_now  = '0;
    dflt_fg        = DefaultFgReset;
    dflt_bg        = DefaultBgReset;
    mismatch_count = 0;
    stall_cycles   = 0;
    in_taken       = 1'b0;
    send_idle_pct  = 21;
    recv_idle_pct  = 85;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Every attribute on, then clear bold, then basic and bright colours.
    add_item(CodeBold, 6);
    add_item(CodeItalic, 5);
    add_item(CodeUnderline, 4);
    add_item(CodeBlink, 3);
    add_item(CodeReverse, 2);
    add_item(CodeHidden, 1);
    add_item(CodeStrike, 0);
    add_item(CodeNoBold, 0);
    add_item(CodeFgBase, 3);
    add_item(CodeBgBase + ColourSpan - 1, 2);
    add_item(CodeFgBright + ColourSpan - 1, 1);
    add_item(CodeBgBright, 0);
    // Indexed and direct colour with values wider than eight bits.
    add_item(CodeFgExtended, 2);
    add_item(ModeIndexed, 1);
    add_item(65535, 0);
    add_item(CodeBgExtended, 4);
    add_item(ModeDirect, 3);
    add_item(255, 2);
    add_item(0, 1);
    add_item(1023, 0);
    // Extended colour with nothing after it is ignored.
    add_item(CodeFgExtended, 0);
    // Direct mode short of values: the rest decode as ordinary codes.
    add_item(CodeBgExtended, 2);
    add_item(ModeDirect, 1);
    add_item(CodeReverse, 0);
    // Indexed mode with nothing after the mode.
    add_item(CodeFgExtended, 1);
    add_item(ModeIndexed, 0);
    // The index is taken whatever count it carries.
    add_item(CodeBgExtended, 2);
    add_item(ModeIndexed, 1);
    add_item(300, 9);
    add_item(65535, 31);
    // The sender waits here until every earlier result has come out.
    add_item(CodeFgDefault, 1, 1'b1);
    add_item(CodeBgDefault, 0);
    add_item(CodeReset, 0);
    wait_until_idle();

    write_default(CfgDefaultFg, 24'hFFFFFF);
    write_default(CfgDefaultBg, 24'h000000);
    run_random(180);
    wait_until_idle();

    send_idle_pct = 85;
    recv_idle_pct = 21;
    write_default(CfgDefaultFg, 24'h000000);
    write_default(CfgDefaultBg, 24'hFFFFFF);
    run_random(180);
    wait_until_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_default(CfgDefaultBg, 24'($urandom));
    write_default(CfgDefaultFg, 24'($urandom));
    run_random(160);
    wait_until_idle();
    repeat (10) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("[sgr_attribute_decoder_top] OK");
    end else begin
      $display("[sgr_attribute_decoder_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/sgr_pkg.sv
src/sgr_decode.sv
src/sgr_attribute_decoder_top.sv
bench/tb.sv
